/* rtl/core/sdes_pkg.sv */
// Shared types, permutation tables and S-box tables for the S-DES byte encryptor.
// No dependencies; used by the interfaces and by every module.
`default_nettype none

package sdes_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [9:0] key_t;
  typedef logic [3:0] half_t;
  typedef logic [7:0] subkey_t;

  typedef struct packed {
    subkey_t k1;
    subkey_t k2;
  } subkeys_t;

  localparam logic [3:0] P10_TAB [10] = '{4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
                                          4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
  localparam logic [3:0] P8_TAB [8] = '{4'd6, 4'd3, 4'd7, 4'd4,
                                        4'd8, 4'd5, 4'd10, 4'd9};
  localparam logic [3:0] IP_TAB [8] = '{4'd2, 4'd6, 4'd3, 4'd1,
                                        4'd4, 4'd8, 4'd5, 4'd7};
  localparam logic [3:0] IPINV_TAB [8] = '{4'd4, 4'd1, 4'd3, 4'd5,
                                           4'd7, 4'd2, 4'd8, 4'd6};
  localparam logic [3:0] EP_TAB [8] = '{4'd4, 4'd1, 4'd2, 4'd3,
                                        4'd2, 4'd3, 4'd4, 4'd1};
  localparam logic [3:0] P4_TAB [4] = '{4'd2, 4'd4, 4'd3, 4'd1};

  localparam logic [1:0] SBOX_A [16] = '{2'd1, 2'd0, 2'd3, 2'd2,
                                         2'd3, 2'd2, 2'd1, 2'd0,
                                         2'd0, 2'd2, 2'd1, 2'd3,
                                         2'd3, 2'd1, 2'd0, 2'd2};
  localparam logic [1:0] SBOX_B [16] = '{2'd0, 2'd1, 2'd2, 2'd3,
                                         2'd2, 2'd3, 2'd1, 2'd0,
                                         2'd3, 2'd0, 2'd1, 2'd2,
                                         2'd2, 2'd1, 2'd0, 2'd3};

  // Table position 1 is the MSB of each word.
  function automatic key_t perm_p10(input key_t v);
    key_t r;
    for (int i = 0; i < 10; i++) begin
      r[9 - i] = v[10 - int'(P10_TAB[i])];
    end
    return r;
  endfunction

  function automatic subkey_t perm_p8(input key_t v);
    subkey_t r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[10 - int'(P8_TAB[i])];
    end
    return r;
  endfunction

  function automatic byte_t perm_ip(input byte_t v);
    byte_t r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[8 - int'(IP_TAB[i])];
    end
    return r;
  endfunction

  function automatic byte_t perm_ipinv(input byte_t v);
    byte_t r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[8 - int'(IPINV_TAB[i])];
    end
    return r;
  endfunction

  function automatic byte_t perm_ep(input half_t v);
    byte_t r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[4 - int'(EP_TAB[i])];
    end
    return r;
  endfunction

  function automatic half_t perm_p4(input half_t v);
    half_t r;
    for (int i = 0; i < 4; i++) begin
      r[3 - i] = v[4 - int'(P4_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [4:0] rotl5(input logic [4:0] v, input int s);
    logic [4:0] r;
    r = v;
    for (int i = 0; i < 2; i++) begin
      if (i < s) begin
        r = {r[3:0], r[4]};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sdes_ifs.sv */
// Valid/ready channel interfaces for plaintext, ciphertext and key transfers.
// Depends on sdes_pkg for payload types.
`default_nettype none

interface sdes_pt_if;
  logic            valid;
  logic            ready;
  sdes_pkg::byte_t plaintext;
  modport source (output valid, output plaintext, input ready);
  modport sink (input valid, input plaintext, output ready);
endinterface

interface sdes_ct_if;
  logic            valid;
  logic            ready;
  sdes_pkg::byte_t ciphertext;
  modport source (output valid, output ciphertext, input ready);
  modport sink (input valid, input ciphertext, output ready);
endinterface

interface sdes_key_if;
  logic           valid;
  logic           ready;
  sdes_pkg::key_t cipher_key;
  modport source (output valid, output cipher_key, input ready);
  modport sink (input valid, input cipher_key, output ready);
endinterface

`default_nettype wire

/* rtl/core/sdes_key_sched.sv */
// Key schedule: P10, half rotations and P8 giving subkeys k1 and k2.
// Depends on sdes_pkg.
`default_nettype none

module sdes_key_sched (
  input  wire sdes_pkg::key_t     key,
  output sdes_pkg::subkeys_t      subkeys
);

  sdes_pkg::key_t   t;
  logic [4:0]       hl1, hr1, hl2, hr2;

  always_comb begin
    t   = sdes_pkg::perm_p10(key);
    hl1 = sdes_pkg::rotl5(t[9:5], 1);
    hr1 = sdes_pkg::rotl5(t[4:0], 1);
    hl2 = sdes_pkg::rotl5(hl1, 2);
    hr2 = sdes_pkg::rotl5(hr1, 2);
    subkeys.k1 = sdes_pkg::perm_p8({hl1, hr1});
    subkeys.k2 = sdes_pkg::perm_p8({hl2, hr2});
  end

endmodule

`default_nettype wire

/* rtl/core/sdes_round.sv */
// One Feistel round: EP, subkey XOR, S-boxes, P4, XOR into the left half.
// Depends on sdes_pkg.
`default_nettype none

module sdes_round (
  input  wire sdes_pkg::half_t   lft,
  input  wire sdes_pkg::half_t   rgt,
  input  wire sdes_pkg::subkey_t subkey,
  output sdes_pkg::half_t        lft_out
);

  sdes_pkg::byte_t e;
  logic [3:0]      idx_a, idx_b;
  sdes_pkg::half_t s;

  always_comb begin
    e       = sdes_pkg::perm_ep(rgt) ^ subkey;
    idx_a   = {e[7], e[4], e[6], e[5]};
    idx_b   = {e[3], e[0], e[2], e[1]};
    s       = {sdes_pkg::SBOX_A[idx_a], sdes_pkg::SBOX_B[idx_b]};
    lft_out = lft ^ sdes_pkg::perm_p4(s);
  end

endmodule

`default_nettype wire

/* rtl/core/sdes_byte_encryptor.sv */
// S-DES byte encryptor top level: input register, two rounds, result register.
// Input bytes are registered in s1_pt_r, the ciphertext then in out_ct_r.
// One byte per cycle unless out_if.ready stalls; the rounds are combinational.
// Reset (rst_n low, synchronous): pipeline empties, key and subkeys read as 0.
// Depends on sdes_pkg, sdes_ifs, sdes_key_sched and sdes_round.
`default_nettype none

module sdes_byte_encryptor (
  input  wire        clk,
  input  wire        rst_n,
  sdes_pt_if.sink    in_if,
  sdes_ct_if.source  out_if,
  sdes_key_if.sink   cfg_if
);

  sdes_pkg::subkeys_t subk_r, subk_nxt;
  logic               s1_valid_r;
  sdes_pkg::byte_t    s1_pt_r;
  logic               out_valid_r;
  sdes_pkg::byte_t    out_ct_r, out_ct_nxt;
  logic               out_adv, s1_adv;
  sdes_pkg::byte_t    x;
  sdes_pkg::half_t    l1, l2;

  sdes_key_sched u_key_sched (
    .key     (cfg_if.cipher_key),
    .subkeys (subk_nxt)
  );

  sdes_round u_round1 (
    .lft     (x[7:4]),
    .rgt     (x[3:0]),
    .subkey  (subk_r.k1),
    .lft_out (l1)
  );

  // swap halves between rounds
  sdes_round u_round2 (
    .lft     (x[3:0]),
    .rgt     (l1),
    .subkey  (subk_r.k2),
    .lft_out (l2)
  );

  always_comb begin
    x          = sdes_pkg::perm_ip(s1_pt_r);
    out_ct_nxt = sdes_pkg::perm_ipinv({l2, l1});
    out_adv    = !out_valid_r || out_if.ready;
    s1_adv     = !s1_valid_r || out_adv;
  end

  assign in_if.ready     = s1_adv;
  assign cfg_if.ready    = 1'b1;
  assign out_if.valid    = out_valid_r;
  assign out_if.ciphertext = out_ct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subk_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        subk_r <= subk_nxt;
      end
      if (s1_adv) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_if.valid) begin
      s1_pt_r <= in_if.plaintext;
    end
    if (out_adv && s1_valid_r) begin
      out_ct_r <= out_ct_nxt;
    end
  end

endmodule

`default_nettype wire

/* sim/sdes_byte_encryptor_test.sv */
// Self-checking testbench for the S-DES byte encryptor: directed and random bytes
// under several keys and backpressure mixes, scored against an in-bench cipher model.
// Depends on sdes_pkg, sdes_ifs and the sdes_byte_encryptor RTL.
`timescale 1ns / 1ps

class sdes_scoreboard;
  localparam logic [31:0] SBOX_A_BITS = {2'd2, 2'd0, 2'd1, 2'd3, 2'd3, 2'd1, 2'd2, 2'd0,
                                         2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1};
  localparam logic [31:0] SBOX_B_BITS = {2'd3, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd3,
                                         2'd0, 2'd1, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};

  sdes_pkg::key_t  cipher_key;
  sdes_pkg::byte_t pending_ct[$];
  int              mismatches;
  int              checked;

  function new();
    cipher_key = '0;
    mismatches = 0;
    checked    = 0;
  endfunction

  function sdes_pkg::half_t round_mix(input sdes_pkg::half_t r, input sdes_pkg::subkey_t k);
    sdes_pkg::byte_t e;
    logic [3:0]      idx_a;
    logic [3:0]      idx_b;
    sdes_pkg::half_t s;
    e     = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ k;
    idx_a = {e[7], e[4], e[6], e[5]};
    idx_b = {e[3], e[0], e[2], e[1]};
    s     = {SBOX_A_BITS[2 * idx_a +: 2], SBOX_B_BITS[2 * idx_b +: 2]};
    return {s[2], s[0], s[1], s[3]};
  endfunction

  function sdes_pkg::byte_t predict_ciphertext(input sdes_pkg::key_t key,
                                               input sdes_pkg::byte_t pt);
    sdes_pkg::key_t    t;
    logic [4:0]        hl;
    logic [4:0]        hr;
    sdes_pkg::key_t    v;
    sdes_pkg::subkey_t k1;
    sdes_pkg::subkey_t k2;
    sdes_pkg::byte_t   x;
    sdes_pkg::half_t   lft;
    sdes_pkg::half_t   rgt;
    sdes_pkg::half_t   tmp;
    sdes_pkg::byte_t   y;
    t  = {key[7], key[5], key[8], key[3], key[6], key[0], key[9], key[1], key[2], key[4]};
    hl = {t[8:5], t[9]};
    hr = {t[3:0], t[4]};
    v  = {hl, hr};
    k1 = {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
    hl = {hl[2:0], hl[4:3]};
    hr = {hr[2:0], hr[4:3]};
    v  = {hl, hr};
    k2 = {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
    x   = {pt[6], pt[2], pt[5], pt[7], pt[4], pt[0], pt[3], pt[1]};
    lft = x[7:4] ^ round_mix(x[3:0], k1);
    rgt = x[3:0];
    tmp = lft;
    lft = rgt;
    rgt = tmp;
    lft = lft ^ round_mix(rgt, k2);
    y   = {lft, rgt};
    return {y[4], y[7], y[5], y[3], y[1], y[6], y[0], y[2]};
  endfunction

  function void note_plaintext(input sdes_pkg::byte_t pt);
    pending_ct.push_back(predict_ciphertext(cipher_key, pt));
  endfunction

  function void check_ciphertext(input sdes_pkg::byte_t ct);
    sdes_pkg::byte_t exp_ct;
    checked++;
    if (pending_ct.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: ciphertext %02h with no transfer outstanding", ct);
      end
    end else begin
      exp_ct = pending_ct.pop_front();
      if (ct !== exp_ct) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: ciphertext expected %02h actual %02h (key %03h)",
                   exp_ct, ct, cipher_key);
        end
      end
    end
  endfunction

  function int pending();
    return pending_ct.size();
  endfunction
endclass

module sdes_byte_encryptor_test;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int LATENCY_PAUSE  = 4;
  localparam int TAIL_CYCLES    = 10;
  localparam int STALL_CYCLES   = 300;
  localparam int BLOCK_ITEMS    = 160;
  localparam int STALL_ITEMS    = 60;
  localparam int KEY_BLOCKS     = 4;

  logic clk;
  logic rst_n;

  sdes_pt_if  pt_ch ();
  sdes_ct_if  ct_ch ();
  sdes_key_if key_ch ();

  sdes_byte_encryptor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pt_ch),
    .out_if (ct_ch),
    .cfg_if (key_ch)
  );

  sdes_scoreboard ct_board;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic stall_req;
  int   sent_count;
  int   keys_written;
  int   cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (key_ch.valid && key_ch.ready) begin
        ct_board.cipher_key = key_ch.cipher_key;
      end
      if (pt_ch.valid && pt_ch.ready) begin
        ct_board.note_plaintext(pt_ch.plaintext);
      end
      if (ct_ch.valid && ct_ch.ready) begin
        ct_board.check_ciphertext(ct_ch.ciphertext);
      end
    end
  end

  initial begin : receiver
    logic stall_seen;
    int   stall_left;
    stall_seen = 1'b0;
    stall_left = 0;
    ct_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        ct_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        stall_left = STALL_CYCLES - 1;
        ct_ch.ready <= 1'b0;
      end else begin
        ct_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_plaintext(input sdes_pkg::byte_t pt);
    while ($urandom_range(99) < tx_idle_pct) begin
      pt_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pt_ch.valid     <= 1'b1;
    pt_ch.plaintext <= pt;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic wait_drained();
    pt_ch.valid <= 1'b0;
    do @(posedge clk); while (ct_board.pending() != 0);
  endtask

  task automatic write_key(input sdes_pkg::key_t key);
    wait_drained();
    repeat (LATENCY_PAUSE) @(posedge clk);
    key_ch.valid      <= 1'b1;
    key_ch.cipher_key <= key;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    key_ch.valid <= 1'b0;
    keys_written++;
  endtask

  task automatic send_edge_bytes();
    sdes_pkg::byte_t edge_bytes [8];
    edge_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0};
    foreach (edge_bytes[i]) send_plaintext(edge_bytes[i]);
  endtask

  initial begin : stimulus
    sdes_pkg::key_t block_key;
    ct_board     = new();
    tx_idle_pct  = 10;
    rx_idle_pct  = 48;
    stall_req    <= 1'b0;
    sent_count   = 0;
    keys_written = 0;
    cycle_count  = 0;
    rst_n             <= 1'b0;
    pt_ch.valid       <= 1'b0;
    pt_ch.plaintext   <= '0;
    key_ch.valid      <= 1'b0;
    key_ch.cipher_key <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key first, then the all-ones key.
    send_edge_bytes();
    write_key(10'h3FF);
    send_edge_bytes();

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 48 : 0;
      rx_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 10 : 0;
      for (int blk = 0; blk < KEY_BLOCKS; blk++) begin
        case (mode * KEY_BLOCKS + blk)
          0:       block_key = 10'h000;
          1:       block_key = 10'h155;
          2:       block_key = 10'h2AA;
          11:      block_key = 10'h3FF;
          default: block_key = sdes_pkg::key_t'($urandom_range(1023));
        endcase
        write_key(block_key);
        repeat (BLOCK_ITEMS) send_plaintext(sdes_pkg::byte_t'($urandom_range(255)));
      end
    end

    // Hold the output off while input keeps coming, then pause until empty.
    write_key(sdes_pkg::key_t'($urandom_range(1023)));
    stall_req <= 1'b1;
    repeat (STALL_ITEMS) send_plaintext(sdes_pkg::byte_t'($urandom_range(255)));
    wait_drained();
    repeat (STALL_ITEMS) send_plaintext(sdes_pkg::byte_t'($urandom_range(255)));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Encrypted %0d bytes under %0d key writes plus the reset key,",
             sent_count, keys_written);
    $display("with mixed input/output gaps and a %0d-cycle output stall; %0d checked.",
             STALL_CYCLES, ct_board.checked);
    if (ct_board.mismatches == 0 && ct_board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", ct_board.mismatches,
               ct_board.pending());
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/sdes_pkg.sv
rtl/core/sdes_ifs.sv
rtl/core/sdes_key_sched.sv
rtl/core/sdes_round.sv
rtl/core/sdes_byte_encryptor.sv
sim/sdes_byte_encryptor_test.sv
